>>> hdl/assert_macros.svh
// Assertion helpers shared by the glyph locator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define FGL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge of clk, reset included.
`define FGL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

>>> hdl/fgl_pkg.sv
package fgl_pkg;

  // Field widths.
  localparam int CODE_W   = 16;
  localparam int OFS_W    = 29;
  localparam int BYTES_W  = 13;
  localparam int DOT_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Range table geometry.
  localparam int MAX_BLOCKS  = 128;
  localparam int TABLE_DEPTH = 128;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 2 * CODE_W;
  localparam int BLOCK_LIMIT = (MAX_BLOCKS < TABLE_DEPTH) ? MAX_BLOCKS : TABLE_DEPTH;
  localparam int BLK_W       = 8;

  // Offset bases and the single-byte code limit.
  localparam int SB_BASE  = 17;
  localparam int DB_BASE  = 18;
  localparam int SB_CODES = 256;

  // Input opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_BYTE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } fgl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;   // write one range entry
    logic start;     // latch a lookup and issue the first table read
    logic scan;      // compare one entry and issue the next read
    logic mul;       // count times glyph size
    logic add;       // add the offset base
    logic out_load;  // move the result into the output register
  } fgl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dbl;          // double-byte font selected
    logic blocks_zero;  // no ranges in use
    logic scan_hit;     // compared entry holds the code
    logic scan_last;    // compared entry is the last one in use
    logic out_busy;     // output register holds a result that is stalled
  } fgl_stat_t;

endpackage

>>> hdl/fontx2_glyph_locator_top.sv
// A single-byte lookup goes from its transfer through ST_MUL, ST_ADD and ST_DONE.
// A double-byte lookup first scans the ranges in ST_SCAN; on a match it goes on to ST_MUL,
// else to ST_DONE after the last of n ranges in use (up to 128), or at once if n is 0.
// The next item is taken the cycle after the result enters the output register, which
// waits while out_stall holds the prior result. Load items write the table, no result.
// Reset (rst_n low, synchronous) restores config registers, clears control; no table clear.
module fontx2_glyph_locator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fgl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fgl_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [fgl_pkg::TBL_AW-1:0]    in_entry_index,
  input  logic [fgl_pkg::CODE_W-1:0]    in_range_first,
  input  logic [fgl_pkg::CODE_W-1:0]    in_range_last,
  input  logic [fgl_pkg::CODE_W-1:0]    in_char_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [fgl_pkg::OFS_W-1:0]     out_glyph_offset,
  output logic [fgl_pkg::BYTES_W-1:0]   out_glyph_bytes
);

  fgl_pkg::fgl_cmd_t  cmd;
  fgl_pkg::fgl_stat_t stat;

  // Sequencer.
  fgl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Registers, range table and offset arithmetic.
  fgl_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_entry_index   (in_entry_index),
    .in_range_first   (in_range_first),
    .in_range_last    (in_range_last),
    .in_char_code     (in_char_code),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_glyph_offset (out_glyph_offset),
    .out_glyph_bytes  (out_glyph_bytes)
  );

endmodule

>>> hdl/fgl_ram.sv
module fgl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/fgl_ctrl.sv
`include "assert_macros.svh"

module fgl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_stall,
  input  fgl_pkg::fgl_stat_t stat,
  output fgl_pkg::fgl_cmd_t  cmd
);

  fgl_pkg::fgl_state_t state_r, state_nxt;
  logic                in_xfer;

  assign in_xfer = in_valid && (state_r == fgl_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fgl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fgl_pkg::ST_IDLE: begin
        if (in_xfer && (in_opcode == fgl_pkg::OP_LOOKUP)) begin
          if (!stat.dbl) begin
            state_nxt = fgl_pkg::ST_MUL;
          end else if (stat.blocks_zero) begin
            state_nxt = fgl_pkg::ST_DONE;
          end else begin
            state_nxt = fgl_pkg::ST_SCAN;
          end
        end
      end
      fgl_pkg::ST_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = fgl_pkg::ST_MUL;
        end else if (stat.scan_last) begin
          state_nxt = fgl_pkg::ST_DONE;
        end
      end
      fgl_pkg::ST_MUL: state_nxt = fgl_pkg::ST_ADD;
      fgl_pkg::ST_ADD: state_nxt = fgl_pkg::ST_DONE;
      fgl_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = fgl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fgl_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      fgl_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_wr = in_xfer && (in_opcode == fgl_pkg::OP_LOAD);
        cmd.start   = in_xfer && (in_opcode == fgl_pkg::OP_LOOKUP);
      end
      fgl_pkg::ST_SCAN: cmd.scan = 1'b1;
      fgl_pkg::ST_MUL:  cmd.mul = 1'b1;
      fgl_pkg::ST_ADD:  cmd.add = 1'b1;
      fgl_pkg::ST_DONE: cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

  // A scan only runs for the block-table font.
  `FGL_ASSERT(a_scan_dbl, (state_r == fgl_pkg::ST_SCAN) |-> stat.dbl)
  // The output register is never overwritten while its result is stalled.
  `FGL_ASSERT(a_no_overwrite, cmd.out_load |-> !stat.out_busy)
  // Once a result is handed over, the next item may enter.
  `FGL_ASSERT(a_load_idle, cmd.out_load |=> (state_r == fgl_pkg::ST_IDLE))
  // The multiply result always gets its add step next.
  `FGL_ASSERT(a_mul_add, (state_r == fgl_pkg::ST_MUL) |=> (state_r == fgl_pkg::ST_ADD))

endmodule

>>> hdl/fgl_datapath.sv
`include "assert_macros.svh"

module fgl_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fgl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fgl_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic [fgl_pkg::TBL_AW-1:0]       in_entry_index,
  input  logic [fgl_pkg::CODE_W-1:0]       in_range_first,
  input  logic [fgl_pkg::CODE_W-1:0]       in_range_last,
  input  logic [fgl_pkg::CODE_W-1:0]       in_char_code,
  input  fgl_pkg::fgl_cmd_t                cmd,
  output fgl_pkg::fgl_stat_t               stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic [fgl_pkg::OFS_W-1:0]        out_glyph_offset,
  output logic [fgl_pkg::BYTES_W-1:0]      out_glyph_bytes
);

  localparam int OFS_W   = fgl_pkg::OFS_W;
  localparam int CODE_W  = fgl_pkg::CODE_W;
  localparam int BYTES_W = fgl_pkg::BYTES_W;
  localparam int BLK_W   = fgl_pkg::BLK_W;

  // Configuration registers.
  logic [fgl_pkg::DOT_W-1:0] glyph_width_r, glyph_height_r;
  logic                      double_byte_r;
  logic [BLK_W-1:0]          block_count_r;

  // Lookup state.
  logic [BYTES_W-1:0]  size_r;
  logic [CODE_W-1:0]   code_r;
  logic [OFS_W-1:0]    count_r;
  logic [BLK_W-1:0]    idx_r;
  logic                hit_r;
  logic [OFS_W-1:0]    prod_r;
  logic [OFS_W-1:0]    offset_r;

  // Output register.
  logic                out_valid_r;
  logic                out_found_r;
  logic [OFS_W-1:0]    out_glyph_offset_r;
  logic [BYTES_W-1:0]  out_glyph_bytes_r;

  // Combinational helpers.
  logic [BLK_W-1:0]                      blocks_n;
  logic [fgl_pkg::DOT_W:0]               width_plus;
  logic [BYTES_W-1:0]                    size_full;
  logic [fgl_pkg::TBL_AW-1:0]            rd_addr;
  logic [fgl_pkg::ENTRY_W-1:0]           rd_data;
  logic [CODE_W-1:0]                     ent_first, ent_last;
  logic                                  scan_hit;
  logic [OFS_W-1:0]                      prod_full;
  logic [OFS_W-1:0]                      base_ofs;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= 8'd16;
      glyph_height_r <= 8'd16;
      double_byte_r  <= 1'b0;
      block_count_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fgl_pkg::CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_data;
        fgl_pkg::CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_data;
        fgl_pkg::CFG_DOUBLE_BYTE:  double_byte_r  <= cfg_data[0];
        fgl_pkg::CFG_BLOCK_COUNT:  block_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Glyph size is ceil(width / 8) bytes per row times the height.
  assign width_plus = {1'b0, glyph_width_r} + 9'd7;
  assign size_full  = {7'd0, width_plus[fgl_pkg::DOT_W:3]} * {5'd0, glyph_height_r};

  always_ff @(posedge clk) begin
    size_r <= size_full;
  end

  // Ranges in use, clipped to the table.
  assign blocks_n = (block_count_r > BLK_W'(fgl_pkg::BLOCK_LIMIT))
                  ? BLK_W'(fgl_pkg::BLOCK_LIMIT) : block_count_r;

  // Range table: first code in the upper half, last code in the lower half.
  assign rd_addr = cmd.start ? '0 : idx_r[fgl_pkg::TBL_AW-1:0];

  fgl_ram #(
    .WIDTH (fgl_pkg::ENTRY_W),
    .DEPTH (fgl_pkg::TABLE_DEPTH)
  ) u_range_ram (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (in_entry_index),
    .wr_data ({in_range_first, in_range_last}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_first = rd_data[fgl_pkg::ENTRY_W-1:CODE_W];
  assign ent_last  = rd_data[CODE_W-1:0];
  assign scan_hit  = (code_r >= ent_first) && (code_r <= ent_last);

  // Offset arithmetic; the product wraps at the offset width.
  assign prod_full = count_r * {{(OFS_W-BYTES_W){1'b0}}, size_r};
  assign base_ofs  = double_byte_r
                   ? OFS_W'(fgl_pkg::DB_BASE) + OFS_W'({blocks_n, 2'b00})
                   : OFS_W'(fgl_pkg::SB_BASE);

  // Lookup sequence: start, scan one entry per cycle (double-byte font only), multiply, add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else if (cmd.start) begin
      code_r <= in_char_code;
      idx_r  <= BLK_W'(1);
      if (double_byte_r) begin
        count_r <= '0;
        hit_r   <= 1'b0;
      end else begin
        count_r <= OFS_W'(in_char_code);
        hit_r   <= in_char_code < CODE_W'(fgl_pkg::SB_CODES);
      end
    end else if (cmd.scan) begin
      if (scan_hit) begin
        count_r <= count_r + OFS_W'(code_r - ent_first);
        hit_r   <= 1'b1;
      end else begin
        count_r <= count_r + OFS_W'(ent_last) - OFS_W'(ent_first) + OFS_W'(1);
        idx_r   <= idx_r + BLK_W'(1);
      end
    end else if (cmd.mul) begin
      prod_r <= prod_full;
    end else if (cmd.add) begin
      offset_r <= base_ofs + prod_r;
    end
  end

  // Output register, parted from the lookup by its own valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r        <= hit_r;
      out_glyph_offset_r <= hit_r ? offset_r : '0;
      out_glyph_bytes_r  <= size_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_glyph_offset = out_glyph_offset_r;
  assign out_glyph_bytes  = out_glyph_bytes_r;

  // Status toward the controller.
  always_comb begin
    stat.dbl         = double_byte_r;
    stat.blocks_zero = (blocks_n == '0);
    stat.scan_hit    = scan_hit;
    stat.scan_last   = (idx_r == blocks_n);
    stat.out_busy    = out_valid_r && out_stall;
  end

  // A matching entry marks the lookup as found.
  `FGL_ASSERT(a_hit_marks, (cmd.scan && scan_hit) |=> hit_r)
  // A code that is not in the font reports offset zero.
  `FGL_ASSERT(a_miss_zero, (out_valid_r && !out_found_r) |-> (out_glyph_offset_r == '0))
  // The scan never runs past the ranges in use.
  `FGL_ASSERT(a_scan_bound, cmd.scan |-> ((idx_r != '0) && (idx_r <= blocks_n)))

endmodule
